// ===== src/sara_pkg.sv =====
// Shared widths, operation codes and types of the swarm accumulator.
package sara_pkg;

	localparam int FIELD_W    = 24;
	localparam int MAG_W      = FIELD_W + 1;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int ROOT_W     = SQ_W / 2;
	localparam int RW         = ROOT_W + 3;
	localparam int WORD_W     = 64;
	localparam int CHUNK_W    = 28;
	localparam int N_CHUNK    = (WORD_W + CHUNK_W - 1) / CHUNK_W;
	localparam int PROD_W     = MAG_W + CHUNK_W;
	localparam int ACC_W      = MAG_W + WORD_W;
	localparam int COEF_SHIFT = 39;
	localparam int FRAC_BITS_DEF = 8;
	localparam int CNT_W      = $clog2(WORD_W);

	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	localparam logic [2:0] REG_GAIN   = 3'd0;
	localparam logic [2:0] REG_MULT   = 3'd1;
	localparam logic [2:0] REG_THRESH = 3'd2;
	localparam logic [2:0] REG_OFF_E  = 3'd3;
	localparam logic [2:0] REG_OFF_N  = 3'd4;
	localparam logic [2:0] REG_OFF_U  = 3'd5;

	typedef struct packed {
		logic start;
		logic op;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_stat_t;

endpackage

// ===== src/sara_iter.sv =====
// Shared shift-subtract unit: restoring division and integer square root.
module sara_iter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sara_pkg::iter_req_t        req,
	input  logic [sara_pkg::WORD_W-1:0] operand,
	input  logic [sara_pkg::RW-1:0]    divisor,
	output logic [sara_pkg::WORD_W-1:0] result,
	output sara_pkg::iter_stat_t       stat
);
	import sara_pkg::*;

	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] quo_q;
	logic [RW-1:0]     rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              op_q;

	logic [RW-1:0] cand;
	logic [RW-1:0] subtrahend;
	logic [RW:0]   sub;
	logic          ge;

	always_comb begin
		if (op_q == OP_SQRT) begin
			cand       = {rem_q[RW-3:0], num_q[WORD_W-1 -: 2]};
			subtrahend = {quo_q[RW-3:0], 2'b01};
		end else begin
			cand       = {rem_q[RW-2:0], num_q[WORD_W-1]};
			subtrahend = divisor;
		end
		sub = {1'b0, cand} - {1'b0, subtrahend};
		ge  = ~sub[RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_SQRT) ? CNT_W'(ROOT_W - 1) : CNT_W'(WORD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= (req.op == OP_SQRT) ? (operand << (WORD_W - SQ_W)) : operand;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= (op_q == OP_SQRT) ? (num_q << 2) : (num_q << 1);
			quo_q <= {quo_q[WORD_W-2:0], ge};
			rem_q <= ge ? sub[RW-1:0] : cand;
		end
	end

	assign result    = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q) else $error("start did not engage");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without run");

endmodule

// ===== src/swarm_attract_repulse_accumulator.sv =====
// Top level: sequencer, shared multiplier and state of the swarm accumulator.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata own/peer E,N,U; tlast round_last; tuser present
//  m_axis    out  tvalid/tready          tdata accel, vel, waypoint E,N,U
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
//  An absent neighbor goes straight to the round-end check. A present neighbor runs the
//  shared shift-subtract unit (25 square-root steps and, unless the clamped distance equals
//  the threshold, three 64-step divisions) plus squares and force products on the one 25x28 multiplier.
//  The last item's round end forms the result. Input is taken only while the sequencer
//  idles; a held result stalls only the round-end step. Reset clears sums and velocity.
module swarm_attract_repulse_accumulator #(
	parameter int FRAC_BITS = sara_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// own_east, own_north, own_up, peer_east, peer_north, peer_up
	input  logic [143:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	// peer_present
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accel_east/north/up, vel_east/north/up, waypoint_east/north/up
	output logic [215:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import sara_pkg::*;

	localparam int DQ_W  = $clog2(25 << FRAC_BITS) + 1;
	localparam int SHF   = COEF_SHIFT - FRAC_BITS;
	localparam logic [ROOT_W-1:0] D_LO = ROOT_W'(1 << FRAC_BITS);
	localparam logic [ROOT_W-1:0] D_HI = ROOT_W'(25 << FRAC_BITS);
	localparam logic [MAG_W-1:0]  LIMIT = MAG_W'(1 << FIELD_W);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQ    = 4'd1;
	localparam logic [3:0] S_SQA   = 4'd2;
	localparam logic [3:0] S_RTGO  = 4'd3;
	localparam logic [3:0] S_RTW   = 4'd4;
	localparam logic [3:0] S_GAIN  = 4'd5;
	localparam logic [3:0] S_GAINA = 4'd6;
	localparam logic [3:0] S_DVGO  = 4'd7;
	localparam logic [3:0] S_DVW   = 4'd8;
	localparam logic [3:0] S_FM    = 4'd9;
	localparam logic [3:0] S_FA    = 4'd10;
	localparam logic [3:0] S_FAPP  = 4'd11;
	localparam logic [3:0] S_END   = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0] state_q;

	logic [15:0]              gain_q;
	logic [7:0]               mult_q;
	logic [15:0]              thr_q;
	logic signed [FIELD_W-1:0] off_q [3];

	logic signed [FIELD_W-1:0] own_q  [3];
	logic signed [MAG_W-1:0]   diff_q [3];
	logic [MAG_W-1:0]          mag_q  [3];
	logic                      last_q;

	logic signed [FIELD_W-1:0] accel_q [3];
	logic signed [FIELD_W-1:0] vel_q   [3];

	logic [SQ_W-1:0]   sq_q;
	logic [DQ_W-1:0]   dq_q;
	logic              attract_q;
	logic              repulse_q;
	logic [FIELD_W-1:0] g_q;
	logic [1:0]        dk_q;
	logic [WORD_W-1:0] c_q;
	logic [1:0]        ax_q;
	logic [1:0]        ck_q;
	logic [ACC_W-1:0]  facc_q;
	logic [PROD_W-1:0] prod_q;

	logic [215:0] out_q;
	logic         out_valid_q;

	logic [MAG_W-1:0]   mul_a;
	logic [CHUNK_W-1:0] mul_b;
	iter_req_t          ireq;
	iter_stat_t         istat;
	logic [WORD_W-1:0]  iop;
	logic [WORD_W-1:0]  ires;
	logic [ROOT_W-1:0]  root_c;
	logic [ROOT_W-1:0]  dq_c;
	logic [ACC_W-1:0]   prod_sh;
	logic [WORD_W-1:0]  p64;
	logic [MAG_W-1:0]   pmag;
	logic               fneg;
	logic signed [FIELD_W+2:0] asum;
	logic [WORD_W-1:0]  c_pad;
	logic [N_CHUNK*CHUNK_W-1:0] c_ext;
	logic               in_xfer;

	function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [FIELD_W+2:0] v);
		logic signed [FIELD_W+2:0] hi;
		logic signed [FIELD_W+2:0] lo;
		hi = (FIELD_W+3)'(2**(FIELD_W-1) - 1);
		lo = -(FIELD_W+3)'(2**(FIELD_W-1));
		if (v > hi) return hi[FIELD_W-1:0];
		if (v < lo) return lo[FIELD_W-1:0];
		return v[FIELD_W-1:0];
	endfunction

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign c_pad = c_q;
	assign c_ext = (N_CHUNK*CHUNK_W)'(c_pad);

	always_comb begin
		mul_a = mag_q[ax_q];
		mul_b = CHUNK_W'(mag_q[ax_q]);
		case (state_q)
			S_GAIN: begin
				mul_a = MAG_W'(gain_q);
				mul_b = attract_q ? CHUNK_W'(1) : CHUNK_W'(mult_q);
			end
			S_FM: begin
				mul_b = c_ext[ck_q*CHUNK_W +: CHUNK_W];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ireq.start = (state_q == S_RTGO) || (state_q == S_DVGO);
		ireq.op    = (state_q == S_RTGO) ? OP_SQRT : OP_DIV;
		if (state_q == S_RTGO)
			iop = WORD_W'(sq_q);
		else if (dk_q == 2'd0)
			iop = WORD_W'(g_q) << COEF_SHIFT;
		else
			iop = ires << FRAC_BITS;
	end

	sara_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ireq),
		.operand (iop),
		.divisor (RW'(dq_q)),
		.result  (ires),
		.stat    (istat)
	);

	always_comb begin
		root_c = ires[ROOT_W-1:0];
		if (root_c < D_LO)
			dq_c = D_LO;
		else if (root_c > D_HI)
			dq_c = D_HI;
		else
			dq_c = root_c;
		prod_sh = ACC_W'(prod_q) << (ck_q * CHUNK_W);
		p64     = facc_q[WORD_W-1:0] >> SHF;
		if (|facc_q[ACC_W-1:WORD_W] || p64 > WORD_W'(LIMIT))
			pmag = LIMIT;
		else
			pmag = p64[MAG_W-1:0];
		fneg = diff_q[ax_q][MAG_W-1] ^ repulse_q;
		asum = (FIELD_W+3)'(accel_q[ax_q])
			+ (fneg ? -(FIELD_W+3)'($signed({1'b0, pmag}))
			        :  (FIELD_W+3)'($signed({1'b0, pmag})));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= 16'd198;
			mult_q   <= 8'd3;
			thr_q    <= 16'((3 << FRAC_BITS) >> 1);
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= FIELD_W'(42 << FRAC_BITS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data[15:0];
				REG_MULT:   mult_q   <= cfg_data[7:0];
				REG_THRESH: thr_q    <= cfg_data[15:0];
				REG_OFF_E:  off_q[0] <= cfg_data;
				REG_OFF_N:  off_q[1] <= cfg_data;
				REG_OFF_U:  off_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ax_q        <= '0;
			ck_q        <= '0;
			dk_q        <= '0;
			last_q      <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				accel_q[i] <= '0;
				vel_q[i]   <= '0;
			end
		end else begin
			if (out_valid_q && m_axis_tready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						last_q    <= s_axis_tlast;
						ax_q      <= '0;
						state_q   <= s_axis_tuser ? S_SQ : S_END;
					end
				end
				S_SQ: state_q <= S_SQA;
				S_SQA: begin
					ax_q    <= ax_q + 1'b1;
					state_q <= (ax_q == 2'd2) ? S_RTGO : S_SQ;
				end
				S_RTGO: state_q <= S_RTW;
				S_RTW: begin
					if (istat.done)
						state_q <= (ROOT_W'(thr_q) == dq_c) ? S_END : S_GAIN;
				end
				S_GAIN:  state_q <= S_GAINA;
				S_GAINA: begin
					dk_q    <= '0;
					state_q <= S_DVGO;
				end
				S_DVGO: state_q <= S_DVW;
				S_DVW: begin
					if (istat.done) begin
						dk_q <= dk_q + 1'b1;
						if (dk_q == 2'd2) begin
							ax_q    <= '0;
							ck_q    <= '0;
							state_q <= S_FM;
						end else begin
							state_q <= S_DVGO;
						end
					end
				end
				S_FM: state_q <= S_FA;
				S_FA: begin
					if (ck_q == 2'(N_CHUNK - 1)) begin
						state_q <= S_FAPP;
					end else begin
						ck_q    <= ck_q + 1'b1;
						state_q <= S_FM;
					end
				end
				S_FAPP: begin
					accel_q[ax_q] <= sat24(asum);
					ax_q          <= ax_q + 1'b1;
					ck_q          <= '0;
					state_q       <= (ax_q == 2'd2) ? S_END : S_FM;
				end
				S_END: state_q <= last_q ? S_FIN : S_IDLE;
				S_FIN: begin
					if (!out_valid_q || m_axis_tready) begin
						for (int i = 0; i < 3; i++) begin
							vel_q[i]   <= sat24((FIELD_W+3)'(vel_q[i]) + (FIELD_W+3)'(accel_q[i]));
							accel_q[i] <= '0;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic signed [FIELD_W-1:0] vn;
		logic signed [FIELD_W-1:0] wp;
		logic signed [MAG_W-1:0]   dv;
		if (in_xfer) begin
			for (int i = 0; i < 3; i++) begin
				dv = MAG_W'($signed(s_axis_tdata[(i+3)*FIELD_W +: FIELD_W]))
					- MAG_W'($signed(s_axis_tdata[i*FIELD_W +: FIELD_W]));
				own_q[i]  <= s_axis_tdata[i*FIELD_W +: FIELD_W];
				diff_q[i] <= dv;
				mag_q[i]  <= dv[MAG_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
			end
			sq_q <= '0;
		end
		if (state_q == S_SQ || state_q == S_GAIN || state_q == S_FM)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (state_q == S_SQA)
			sq_q <= sq_q + prod_q[SQ_W-1:0];
		if (state_q == S_RTW && istat.done) begin
			dq_q      <= dq_c[DQ_W-1:0];
			attract_q <= dq_c > ROOT_W'(thr_q);
			repulse_q <= dq_c < ROOT_W'(thr_q);
		end
		if (state_q == S_GAINA)
			g_q <= prod_q[FIELD_W-1:0];
		if (state_q == S_DVW && istat.done && dk_q == 2'd2)
			c_q <= ires;
		if (state_q == S_FM && ck_q == 2'd0)
			facc_q <= '0;
		if (state_q == S_FA)
			facc_q <= ((ck_q == 2'd0) ? '0 : facc_q) + prod_sh;
		if (state_q == S_FIN && (!out_valid_q || m_axis_tready)) begin
			for (int i = 0; i < 3; i++) begin
				vn = sat24((FIELD_W+3)'(vel_q[i]) + (FIELD_W+3)'(accel_q[i]));
				wp = sat24((FIELD_W+3)'(own_q[i]) + (FIELD_W+3)'(vn));
				wp = sat24((FIELD_W+3)'(wp) + (FIELD_W+3)'(off_q[i]));
				out_q[i*FIELD_W +: FIELD_W]     <= accel_q[i];
				out_q[(i+3)*FIELD_W +: FIELD_W] <= vn;
				out_q[(i+6)*FIELD_W +: FIELD_W] <= wp;
			end
		end
	end

	a_fin_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid_q) |=> out_valid_q) else $error("result not emitted");
	a_absent_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !s_axis_tuser) |=> state_q == S_END) else $error("absent item ran unit");
	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !istat.busy) else $error("unit busy while idle");

endmodule
